@@ rtl/length_prefixed_request_deframer_assert.svh @@
// Assertion macros shared by the deframer RTL.
`ifndef LENGTH_PREFIXED_REQUEST_DEFRAMER_ASSERT_SVH
`define LENGTH_PREFIXED_REQUEST_DEFRAMER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LPRD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("deframer assertion failed");

// Next-cycle implication, disabled during reset.
`define LPRD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("deframer assertion failed");

`endif

@@ rtl/lprd_pkg.sv @@
`timescale 1ns / 1ps

package lprd_pkg;

    localparam int unsigned MAX_FRAME_BYTES_DEF = 4096;
    localparam int unsigned LIMIT_W             = 13;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 13'd4096;
    localparam int unsigned BYTE_W              = 8;
    localparam int unsigned WORD_W              = 32;
    localparam int unsigned STR_NUM_W           = 10;
    localparam int unsigned KIND_W              = 2;
    localparam int unsigned ERR_W               = 3;
    localparam int unsigned M_TDATA_W           = 24;
    localparam logic [WORD_W-1:0] LEN_FIELD_BYTES = 32'd4;

    typedef enum logic [KIND_W-1:0] {
        KIND_BYTE      = 2'd0,
        KIND_EMPTY_STR = 2'd1,
        KIND_EMPTY_REQ = 2'd2,
        KIND_ERROR     = 2'd3
    } t_kind;

    typedef enum logic [ERR_W-1:0] {
        ERR_TOO_LONG  = 3'd0,
        ERR_COUNT     = 3'd1,
        ERR_TRUNC_LEN = 3'd2,
        ERR_OVERRUN   = 3'd3,
        ERR_TRAILING  = 3'd4
    } t_err;

    typedef struct packed {
        t_kind                 kind;
        logic [BYTE_W-1:0]     payload;
        logic [STR_NUM_W-1:0]  string_number;
        logic                  string_end;
        logic                  request_end;
        t_err                  error_code;
    } t_result;

endpackage

@@ rtl/length_prefixed_request_deframer.sv @@
`timescale 1ns / 1ps
// Deframes a byte stream of length-prefixed requests: a 4-byte big-endian body length, a
// little-endian 32-bit string count, then each string as a little-endian 32-bit length and
// its bytes. Every string byte leaves as one transaction tagged with its string index and
// end flags; empty strings and empty requests get marker transactions, and the first framing
// error produces one error transaction, after which all input is dropped until reset. One
// byte is taken every cycle while the output is not stalled, and its result passes from the
// input register to the output register through the per-byte state update, which sets the
// rate and is combinational. The frame limit may only be written while idle.
`include "length_prefixed_request_deframer_assert.svh"

module length_prefixed_request_deframer #(
    parameter int unsigned MAX_FRAME_BYTES = lprd_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [lprd_pkg::LIMIT_W-1:0]          i_cfg_wdata,
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    // data_byte[7:0]
    input  logic [lprd_pkg::BYTE_W-1:0]           i_s_tdata,
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    // payload[7:0], string_number[17:8], string_end[18], error_code[21:19], zero[23:22]
    output logic [lprd_pkg::M_TDATA_W-1:0]        o_m_tdata,
    // kind[1:0]
    output logic [lprd_pkg::KIND_W-1:0]           o_m_tuser,
    output logic                                  o_m_tlast
);

    localparam logic [lprd_pkg::WORD_W-1:0] MaxLimit = lprd_pkg::WORD_W'(MAX_FRAME_BYTES);

    typedef enum logic [1:0] {
        PH_HDR   = 2'd0,
        PH_COUNT = 2'd1,
        PH_LEN   = 2'd2,
        PH_DATA  = 2'd3
    } t_phase;

    t_phase                              r_phase, n_phase;
    logic [1:0]                          r_fcnt, n_fcnt;
    logic [lprd_pkg::WORD_W-1:0]         r_word, n_word;
    logic [lprd_pkg::LIMIT_W-1:0]        r_frem, n_frem;
    logic [lprd_pkg::WORD_W-1:0]         r_sleft, n_sleft;
    logic [lprd_pkg::LIMIT_W-1:0]        r_sbleft, n_sbleft;
    logic [lprd_pkg::STR_NUM_W-1:0]      r_cur, n_cur;
    logic                                r_closed, n_closed;
    logic [lprd_pkg::LIMIT_W-1:0]        r_limit;
    logic                                r_in_valid;
    logic [lprd_pkg::BYTE_W-1:0]         r_in_byte;
    logic                                r_out_valid;
    lprd_pkg::t_result                   r_out;

    lprd_pkg::t_result                   res;
    logic                                res_valid;
    logic                                advance;
    logic [lprd_pkg::WORD_W-1:0]         limit_eff;
    logic [lprd_pkg::WORD_W-1:0]         hdr_word;
    logic [lprd_pkg::WORD_W-1:0]         le_word;
    logic [lprd_pkg::LIMIT_W-1:0]        frem_dec;
    logic [lprd_pkg::LIMIT_W-1:0]        sb_dec;
    logic [lprd_pkg::WORD_W-1:0]         sl_dec;
    logic                                as_go;
    lprd_pkg::t_kind                     as_kind;
    logic [lprd_pkg::BYTE_W-1:0]         as_byte;

    assign limit_eff = ({19'd0, r_limit} < MaxLimit) ? {19'd0, r_limit} : MaxLimit;
    assign hdr_word  = {r_word[23:0], r_in_byte};
    assign le_word   = {r_in_byte, r_word[31:8]};
    assign frem_dec  = (r_frem != '0) ? r_frem - 1'b1 : r_frem;
    assign sb_dec    = (r_sbleft != '0) ? r_sbleft - 1'b1 : r_sbleft;
    assign sl_dec    = r_sleft - 1'b1;

    always_comb begin
        n_phase   = r_phase;
        n_fcnt    = r_fcnt;
        n_word    = r_word;
        n_frem    = r_frem;
        n_sleft   = r_sleft;
        n_sbleft  = r_sbleft;
        n_cur     = r_cur;
        n_closed  = r_closed;
        res_valid = 1'b0;
        res       = '0;
        as_go     = 1'b0;
        as_kind   = lprd_pkg::KIND_BYTE;
        as_byte   = '0;

        if (!r_closed) begin
            case (r_phase)
                PH_HDR: begin
                    n_word = hdr_word;
                    n_fcnt = r_fcnt + 1'b1;
                    if (r_fcnt == 2'd3) begin
                        if (hdr_word > limit_eff) begin
                            n_closed = 1'b1;
                            res_valid = 1'b1;
                            res.kind = lprd_pkg::KIND_ERROR;
                            res.error_code = lprd_pkg::ERR_TOO_LONG;
                        end else if (hdr_word < lprd_pkg::LEN_FIELD_BYTES) begin
                            n_closed = 1'b1;
                            res_valid = 1'b1;
                            res.kind = lprd_pkg::KIND_ERROR;
                            res.error_code = lprd_pkg::ERR_COUNT;
                        end else begin
                            n_frem  = hdr_word[lprd_pkg::LIMIT_W-1:0];
                            n_word  = '0;
                            n_phase = PH_COUNT;
                        end
                    end
                end
                PH_COUNT, PH_LEN: begin
                    n_frem = frem_dec;
                    n_word = le_word;
                    n_fcnt = r_fcnt + 1'b1;
                    if (r_fcnt == 2'd3) begin
                        if (r_phase == PH_COUNT) begin
                            n_sleft = le_word;
                            n_cur   = '0;
                            if (le_word == '0) begin
                                res_valid = 1'b1;
                                n_phase   = PH_HDR;
                                if (frem_dec != '0) begin
                                    n_closed = 1'b1;
                                    res.kind = lprd_pkg::KIND_ERROR;
                                    res.error_code = lprd_pkg::ERR_TRAILING;
                                end else begin
                                    n_word = '0;
                                    res.kind = lprd_pkg::KIND_EMPTY_REQ;
                                    res.request_end = 1'b1;
                                end
                            end else if ({19'd0, frem_dec} < lprd_pkg::LEN_FIELD_BYTES) begin
                                n_closed = 1'b1;
                                n_phase = PH_HDR;
                                res_valid = 1'b1;
                                res.kind = lprd_pkg::KIND_ERROR;
                                res.error_code = lprd_pkg::ERR_TRUNC_LEN;
                            end else begin
                                n_phase = PH_LEN;
                                n_word  = '0;
                            end
                        end else begin
                            n_sbleft = le_word[lprd_pkg::LIMIT_W-1:0];
                            if (le_word > {19'd0, frem_dec}) begin
                                n_closed = 1'b1;
                                n_phase = PH_HDR;
                                res_valid = 1'b1;
                                res.kind = lprd_pkg::KIND_ERROR;
                                res.error_code = lprd_pkg::ERR_OVERRUN;
                            end else if (le_word == '0) begin
                                as_go   = 1'b1;
                                as_kind = lprd_pkg::KIND_EMPTY_STR;
                            end else begin
                                n_phase = PH_DATA;
                            end
                        end
                    end
                end
                PH_DATA: begin
                    n_frem   = frem_dec;
                    n_sbleft = sb_dec;
                    if (sb_dec != '0) begin
                        res_valid = 1'b1;
                        res.kind = lprd_pkg::KIND_BYTE;
                        res.payload = r_in_byte;
                        res.string_number = r_cur;
                    end else begin
                        as_go   = 1'b1;
                        as_kind = lprd_pkg::KIND_BYTE;
                        as_byte = r_in_byte;
                    end
                end
                default: begin
                    n_phase = PH_HDR;
                    n_fcnt  = '0;
                    n_word  = '0;
                end
            endcase

            if (as_go) begin
                n_sleft   = sl_dec;
                n_cur     = r_cur + 1'b1;
                res_valid = 1'b1;
                if (sl_dec == '0) begin
                    n_phase = PH_HDR;
                    n_fcnt  = '0;
                    if (frem_dec != '0) begin
                        n_closed = 1'b1;
                        res.kind = lprd_pkg::KIND_ERROR;
                        res.error_code = lprd_pkg::ERR_TRAILING;
                    end else begin
                        n_word = '0;
                        n_cur  = '0;
                        res.kind = as_kind;
                        res.payload = as_byte;
                        res.string_number = r_cur;
                        res.string_end = 1'b1;
                        res.request_end = 1'b1;
                    end
                end else if ({19'd0, frem_dec} < lprd_pkg::LEN_FIELD_BYTES) begin
                    n_closed = 1'b1;
                    n_phase = PH_HDR;
                    n_fcnt  = '0;
                    res.kind = lprd_pkg::KIND_ERROR;
                    res.error_code = lprd_pkg::ERR_TRUNC_LEN;
                end else begin
                    n_phase = PH_LEN;
                    n_word  = '0;
                    n_fcnt  = '0;
                    res.kind = as_kind;
                    res.payload = as_byte;
                    res.string_number = r_cur;
                    res.string_end = 1'b1;
                end
            end
        end
    end

    assign advance    = r_in_valid && (!res_valid || !r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HDR;
            r_fcnt      <= '0;
            r_word      <= '0;
            r_frem      <= '0;
            r_sleft     <= '0;
            r_sbleft    <= '0;
            r_cur       <= '0;
            r_closed    <= 1'b0;
            r_limit     <= lprd_pkg::LIMIT_RESET;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (advance) begin
                r_phase  <= n_phase;
                r_fcnt   <= n_fcnt;
                r_word   <= n_word;
                r_frem   <= n_frem;
                r_sleft  <= n_sleft;
                r_sbleft <= n_sbleft;
                r_cur    <= n_cur;
                r_closed <= n_closed;
            end
            if (advance && res_valid) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready) begin
            r_in_byte <= i_s_tdata;
        end
        if (advance && res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.kind;
    assign o_m_tlast  = r_out.request_end;
    assign o_m_tdata  = {2'b00, r_out.error_code, r_out.string_end,
                         r_out.string_number, r_out.payload};

    `LPRD_ASSERT_NEXT(a_error_closes, i_clk, i_rst_n,
        advance && res_valid && (res.kind == lprd_pkg::KIND_ERROR), r_closed)
    `LPRD_ASSERT_NEXT(a_closed_is_quiet, i_clk, i_rst_n,
        r_closed && !o_m_tvalid, !o_m_tvalid)
    `LPRD_ASSERT_NOW(a_request_end_shape, i_clk, i_rst_n,
        o_m_tvalid && o_m_tlast,
        (o_m_tuser == lprd_pkg::KIND_EMPTY_REQ) || o_m_tdata[18])

endmodule

@@ sim/length_prefixed_request_deframer_test.sv @@
`timescale 1ns / 1ps

module length_prefixed_request_deframer_test;
    import lprd_pkg::*;

    localparam int unsigned MAX_BODY      = MAX_FRAME_BYTES_DEF;
    localparam int unsigned LARGE_BODY    = 96;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned TIMEOUT_NS    = 10_000_000;
    localparam int unsigned PHASE_BYTES   = 150;

    // Non-error results carry a zero error code.
    localparam t_err ERR_NONE = ERR_TOO_LONG;

    typedef enum logic [1:0] {
        PARSE_HEADER,
        PARSE_COUNT,
        PARSE_LENGTH,
        PARSE_DATA
    } t_parse;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [LIMIT_W-1:0]   i_cfg_wdata = '0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [BYTE_W-1:0]    i_s_tdata = '0;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [M_TDATA_W-1:0] o_m_tdata;
    logic [KIND_W-1:0]    o_m_tuser;
    logic                 o_m_tlast;

    length_prefixed_request_deframer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

    logic [LIMIT_W-1:0]   limit_reg = LIMIT_RESET;
    t_parse               parse_state = PARSE_HEADER;
    logic [1:0]           field_count = '0;
    logic [31:0]          word_acc = '0;
    logic [LIMIT_W-1:0]   body_left = '0;
    logic [31:0]          strings_left = '0;
    logic [31:0]          string_left = '0;
    logic [STR_NUM_W-1:0] string_index = '0;
    logic                 stream_closed = 1'b0;

    t_result              pending_results[$];
    logic [7:0]           frame_q[$];
    logic [7:0]           body_q[$];

    int unsigned          send_idle_pct = 0;
    int unsigned          recv_stall_pct = 0;
    int unsigned          fail_count = 0;
    int unsigned          phase_bytes = 0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("length_prefixed_request_deframer verification failed");
        $finish;
    end

    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic void expect_result(t_kind kind, logic [7:0] payload,
                                          logic [STR_NUM_W-1:0] number, logic str_end,
                                          logic req_end, t_err code);
        t_result r;
        r.kind          = kind;
        r.payload       = payload;
        r.string_number = number;
        r.string_end    = str_end;
        r.request_end   = req_end;
        r.error_code    = code;
        pending_results.push_back(r);
    endfunction

    function automatic void flag_error(t_err code);
        stream_closed = 1'b1;
        parse_state   = PARSE_HEADER;
        field_count   = '0;
        expect_result(KIND_ERROR, 8'd0, '0, 1'b0, 1'b0, code);
    endfunction

    function automatic void close_string(t_kind kind, logic [7:0] b);
        logic [STR_NUM_W-1:0] number;
        number       = string_index;
        strings_left = strings_left - 32'd1;
        string_index = string_index + 1'b1;
        if (strings_left == 0) begin
            if (body_left != 0) begin
                flag_error(ERR_TRAILING);
            end else begin
                parse_state  = PARSE_HEADER;
                field_count  = '0;
                word_acc     = '0;
                string_index = '0;
                expect_result(kind, b, number, 1'b1, 1'b1, ERR_NONE);
            end
        end else if (body_left < LEN_FIELD_BYTES) begin
            flag_error(ERR_TRUNC_LEN);
        end else begin
            parse_state = PARSE_LENGTH;
            word_acc    = '0;
            field_count = '0;
            expect_result(kind, b, number, 1'b1, 1'b0, ERR_NONE);
        end
    endfunction

    function automatic void deframe_byte(logic [7:0] b);
        logic [31:0] cap;
        if (stream_closed) return;
        if (parse_state == PARSE_HEADER) begin
            word_acc    = {word_acc[23:0], b};
            field_count = field_count + 2'd1;
            if (field_count != 0) return;
            cap = (limit_reg < MAX_BODY) ? 32'(limit_reg) : 32'(MAX_BODY);
            if (word_acc > cap) begin
                flag_error(ERR_TOO_LONG);
            end else if (word_acc < LEN_FIELD_BYTES) begin
                flag_error(ERR_COUNT);
            end else begin
                body_left   = word_acc[LIMIT_W-1:0];
                word_acc    = '0;
                parse_state = PARSE_COUNT;
            end
            return;
        end
        if (body_left != 0) body_left = body_left - 1'b1;
        if (parse_state == PARSE_DATA) begin
            if (string_left != 0) string_left = string_left - 32'd1;
            if (string_left != 0) begin
                expect_result(KIND_BYTE, b, string_index, 1'b0, 1'b0, ERR_NONE);
            end else begin
                close_string(KIND_BYTE, b);
            end
            return;
        end
        word_acc    = {b, word_acc[31:8]};
        field_count = field_count + 2'd1;
        if (field_count != 0) return;
        if (parse_state == PARSE_COUNT) begin
            strings_left = word_acc;
            string_index = '0;
            if (strings_left == 0) begin
                if (body_left != 0) begin
                    flag_error(ERR_TRAILING);
                end else begin
                    parse_state = PARSE_HEADER;
                    word_acc    = '0;
                    expect_result(KIND_EMPTY_REQ, 8'd0, '0, 1'b0, 1'b1, ERR_NONE);
                end
            end else if (body_left < LEN_FIELD_BYTES) begin
                flag_error(ERR_TRUNC_LEN);
            end else begin
                parse_state = PARSE_LENGTH;
                word_acc    = '0;
                field_count = '0;
            end
        end else begin
            string_left = word_acc;
            if (string_left > body_left) begin
                flag_error(ERR_OVERRUN);
            end else if (string_left == 0) begin
                close_string(KIND_EMPTY_STR, 8'd0);
            end else begin
                parse_state = PARSE_DATA;
            end
        end
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                $error("kind: expected no transaction, got %0d", o_m_tuser);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("kind", want.kind, o_m_tuser);
                check_field("payload", want.payload, o_m_tdata[7:0]);
                check_field("string_number", want.string_number, o_m_tdata[17:8]);
                check_field("string_end", want.string_end, o_m_tdata[18]);
                check_field("request_end", want.request_end, o_m_tlast);
                check_field("error_code", want.error_code, o_m_tdata[21:19]);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        deframe_byte(b);
        phase_bytes++;
    endtask

    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_frame_limit(input logic [LIMIT_W-1:0] value);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        limit_reg = value;
    endtask

    function automatic void put_le32(ref logic [7:0] q[$], input logic [31:0] v);
        for (int i = 0; i < 4; i++) q.push_back(v[8*i +: 8]);
    endfunction

    function automatic void add_random_bytes(int unsigned n);
        repeat (n) body_q.push_back(8'($urandom_range(255)));
    endfunction

    function automatic void add_random_string(int unsigned len);
        put_le32(body_q, len);
        add_random_bytes(len);
    endfunction

    function automatic void seal_frame(logic [31:0] body_len, logic [31:0] count);
        frame_q.delete();
        for (int i = 3; i >= 0; i--) frame_q.push_back(body_len[8*i +: 8]);
        put_le32(frame_q, count);
        foreach (body_q[i]) frame_q.push_back(body_q[i]);
        body_q.delete();
    endfunction

    function automatic void build_random_frame(int unsigned cap);
        int unsigned goal, room, len, count, pick;
        logic        short_mode;
        short_mode = ($urandom_range(9) == 0);
        goal  = short_mode ? $urandom_range(40) : $urandom_range(5);
        room  = cap - 4;
        count = 0;
        body_q.delete();
        for (int i = 0; i < goal; i++) begin
            if (room < 4) break;
            room -= 4;
            pick = $urandom_range(19);
            if (short_mode) len = $urandom_range(3);
            else if (pick < 2) len = 0;
            else if (pick < 16) len = $urandom_range(1, 12);
            else if (pick < 19) len = $urandom_range(13, 80);
            else len = $urandom_range(81, 600);
            if (len > room) len = room;
            room -= len;
            add_random_string(len);
            count++;
        end
        seal_frame(body_q.size() + 4, count);
    endfunction

    task automatic send_frame(input int pause_at);
        foreach (frame_q[i]) begin
            if (i == pause_at) drain_results();
            send_byte(frame_q[i]);
        end
    endtask

    task automatic test_directed_frames();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_frame_limit(13'd4096);
        seal_frame(4, 0);
        send_frame(-1);
        add_random_string(0);
        seal_frame(8, 1);
        send_frame(-1);
        put_le32(body_q, 1);
        body_q.push_back(8'h00);
        seal_frame(9, 1);
        send_frame(-1);
        put_le32(body_q, 4);
        body_q.push_back(8'hFF);
        body_q.push_back(8'h00);
        body_q.push_back(8'h80);
        body_q.push_back(8'h7F);
        add_random_string(0);
        put_le32(body_q, 1);
        body_q.push_back(8'hFF);
        seal_frame(4 + body_q.size(), 3);
        send_frame(-1);
        write_frame_limit(13'd4);
        seal_frame(4, 0);
        send_frame(-1);
    endtask

    task automatic test_largest_frames();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_frame_limit(LIMIT_W'(LARGE_BODY));
        add_random_string(LARGE_BODY - 8);
        seal_frame(LARGE_BODY, 1);
        send_frame(-1);
        send_idle_pct  = 26;
        recv_stall_pct = 26;
        repeat ((LARGE_BODY - 4) / 4) add_random_string(0);
        seal_frame(LARGE_BODY, (LARGE_BODY - 4) / 4);
        send_frame(-1);
    endtask

    task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct,
                                       input logic [LIMIT_W-1:0] limit);
        write_frame_limit(limit);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        phase_bytes    = 0;
        while (phase_bytes < PHASE_BYTES) begin
            build_random_frame(limit);
            send_frame(-1);
        end
    endtask

    task automatic test_pause_mid_frame();
        write_frame_limit(13'd4096);
        send_idle_pct  = 26;
        recv_stall_pct = 26;
        repeat (3) begin
            build_random_frame(200);
            send_frame($urandom_range(1, frame_q.size() - 1));
        end
    endtask

    task automatic test_framing_error();
        t_err        code;
        int unsigned k, r;
        logic [LIMIT_W-1:0] lim;
        send_idle_pct  = 26;
        recv_stall_pct = 26;
        code = t_err'($urandom_range(4));
        k = $urandom_range(8);
        r = $urandom_range(3);
        body_q.delete();
        case (code)
            ERR_TOO_LONG: begin
                lim = $urandom_range(1) ? 13'd0 : LIMIT_W'($urandom_range(4095));
                write_frame_limit(lim);
                add_random_bytes(8);
                if ($urandom_range(1))
                    seal_frame(32'(lim) + 1 + $urandom_range(50), $urandom());
                else
                    seal_frame($urandom() | 32'h0001_0000, $urandom());
            end
            ERR_COUNT: begin
                add_random_bytes(4);
                seal_frame($urandom_range(3), $urandom());
            end
            ERR_TRUNC_LEN: begin
                if ($urandom_range(1)) begin
                    add_random_bytes(r);
                    seal_frame(4 + r, $urandom_range(1, 1000));
                end else begin
                    add_random_string(k);
                    add_random_bytes(r);
                    seal_frame(8 + k + r, $urandom_range(2, 1000));
                end
            end
            ERR_OVERRUN: begin
                put_le32(body_q, k + 1 + $urandom_range(100));
                add_random_bytes(k);
                seal_frame(8 + k, $urandom_range(1, 1000));
            end
            default: begin
                r = r + 1;
                if ($urandom_range(1)) begin
                    add_random_bytes(r);
                    seal_frame(4 + r, 0);
                end else begin
                    add_random_string(k);
                    add_random_bytes(r);
                    seal_frame(8 + k + r, 1);
                end
            end
        endcase
        send_frame(-1);
        write_frame_limit(13'd0);
        build_random_frame(MAX_BODY);
        send_frame(-1);
        add_random_bytes(40);
        frame_q = body_q;
        body_q.delete();
        send_frame(-1);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_frames();
        test_largest_frames();
        test_random_traffic(0, 0, 13'd8191);
        test_random_traffic(45, 0, LIMIT_W'($urandom_range(4, 4096)));
        test_random_traffic(0, 45, LIMIT_W'($urandom_range(4, 64)));
        test_random_traffic(26, 26, 13'd4096);
        test_pause_mid_frame();
        test_framing_error();
        drain_results();
        if (fail_count == 0) begin
            $display("length_prefixed_request_deframer verification clean");
        end else begin
            $display("length_prefixed_request_deframer verification failed");
        end
        $finish;
    end

endmodule
